// ===== hw/rtl/wss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Work segment scoreboard package
// Shared types and codes for the scoreboard core and its testbench.
// ----------------------------------------------------------------------------
package wss_pkg;

   localparam int unsigned FIELD_W = 13;
   localparam int unsigned KEY_W   = 48;

   typedef enum logic [2:0] {
      MODE_ASSIGN   = 3'd0,
      MODE_COMPLETE = 3'd1,
      MODE_RECLAIM  = 3'd2,
      MODE_TAG      = 3'd3,
      MODE_RELABEL  = 3'd4,
      MODE_QUERY    = 3'd5
   } mode_type;

   localparam logic [1:0] ENTRY_TODO   = 2'd0;
   localparam logic [1:0] ENTRY_INPROG = 2'd1;
   localparam logic [1:0] ENTRY_DONE   = 2'd2;
   localparam logic [1:0] ENTRY_FAIL   = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_RANGE    = 2'd1;
   localparam logic [1:0] STATUS_NOCLIENT = 2'd2;
   localparam logic [1:0] STATUS_FULL     = 2'd3;

   typedef enum logic [2:0] {
      WSS_CLEAR,
      WSS_IDLE,
      WSS_SEARCH,
      WSS_PAINT,
      WSS_QUERY,
      WSS_QWAIT,
      WSS_RESP
   } wss_state_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] client_ip;
      logic [15:0] client_port;
      logic [12:0] seg_begin;
      logic [12:0] seg_end;
      logic [1:0]  new_state;
      logic [1:0]  old_state;
      logic [11:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [12:0] seg_start;
      logic [1:0]  entry_state;
      logic [12:0] todo_count;
      logic [12:0] inprogress_count;
      logic [12:0] done_count;
      logic [12:0] fail_count;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [FIELD_W-1:0] first;
      logic [FIELD_W-1:0] last;
   } slot_type;

   localparam int unsigned SLOT_W = $bits(slot_type);

endpackage

// ===== hw/rtl/wss_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wss_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/work_segment_scoreboard_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Work segment scoreboard core
// Keeps a state per work entry, counts per state and a client segment table.
// ----------------------------------------------------------------------------
//  Channel | Direction | Ports
//  request | in        | req_valid, req_ready, req_data
//  response| out       | rsp_valid, rsp_ready, rsp_data
//  config  | in        | csr_wr_en, csr_wr_data
//
// From acceptance to response: assign, complete and reclaim search the client
// table, then paint their segment; tag range paints its segment, relabel the
// first job_size entries, query reads one entry, and a rejected request skips
// the paint. The entry RAM port handles one entry per cycle. After reset and
// after each job_size write a clearing pass over all NUM_ENTRIES entries
// runs; a new request is accepted while the previous response waits.
// ----------------------------------------------------------------------------
module work_segment_scoreboard_core #(
   parameter int unsigned NUM_ENTRIES  = 4096,
   parameter int unsigned CLIENT_SLOTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wss_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [12:0]      csr_wr_data
);
   import wss_pkg::*;

   localparam int unsigned AW = $clog2(NUM_ENTRIES);
   localparam int unsigned CW = AW + 1;
   localparam int unsigned SW = $clog2(CLIENT_SLOTS);

   function automatic logic [FIELD_W-1:0] clamp_size(input logic [FIELD_W-1:0] v);
      logic [31:0] wide;
      wide = 32'(v);
      if (wide > 32'(NUM_ENTRIES)) begin
         return FIELD_W'(NUM_ENTRIES);
      end
      return v;
   endfunction

   wss_state_type      state_ff, state_in;
   logic [2:0]         mode_ff, mode_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [FIELD_W-1:0] b_ff, b_in, e_ff, e_in;
   logic [1:0]         ost_ff, ost_in;
   logic [11:0]        idx_ff, idx_in;
   logic [FIELD_W-1:0] job_ff, job_in;
   logic [FIELD_W-1:0] cnt_ff [4];
   logic [FIELD_W-1:0] cnt_in [4];
   logic [CLIENT_SLOTS-1:0] valid_ff, valid_in;
   logic [SW:0]        sp_ff, sp_in;
   logic               rd_live_ff, rd_live_in;
   logic [SW-1:0]      rd_slot_ff, rd_slot_in;
   logic               free_ok_ff, free_ok_in;
   logic [SW-1:0]      free_slot_ff, free_slot_in;
   logic [CW-1:0]      ptr_ff, ptr_in, lim_ff, lim_in;
   logic               p_live_ff, p_live_in;
   logic [AW-1:0]      p_addr_ff, p_addr_in;
   logic [1:0]         pnew_ff, pnew_in;
   logic               pfilt_ff, pfilt_in;
   logic [1:0]         status_ff, status_in;
   logic [FIELD_W-1:0] start_ff, start_in;
   logic [1:0]         qst_ff, qst_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               e_wr_en;
   logic [AW-1:0]      e_wr_addr, e_rd_addr;
   logic [1:0]         e_wr_data, e_rd_data;
   logic               s_wr_en;
   logic [SW-1:0]      s_wr_addr;
   slot_type           s_wr_data, s_rd;
   logic [SLOT_W-1:0]  s_rd_raw;

   logic               accept;
   logic               req_rng_ok, slot_rng_ok, search_hit, search_end, paint_end;
   logic               query_bad, clear_end, p_write;
   logic [KEY_W-1:0]   req_key;

   assign accept      = req_valid && req_ready;
   assign req_key     = {req_data.client_ip, req_data.client_port};
   assign req_rng_ok  = (req_data.seg_begin <= job_ff) && (req_data.seg_end <= job_ff);
   assign query_bad   = {1'b0, req_data.entry_index} >= job_ff;
   assign s_rd        = slot_type'(s_rd_raw);
   assign slot_rng_ok = (s_rd.first <= job_ff) && (s_rd.last <= job_ff);
   assign search_hit  = rd_live_ff && valid_ff[rd_slot_ff] && (s_rd.key == key_ff);
   assign search_end  = search_hit || (!rd_live_ff && (sp_ff == (SW+1)'(CLIENT_SLOTS)));
   assign paint_end   = !p_live_ff && (ptr_ff >= lim_ff);
   assign clear_end   = ptr_ff == CW'(NUM_ENTRIES - 1);
   assign p_write     = p_live_ff && (!pfilt_ff || (e_rd_data == ost_ff));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         WSS_CLEAR: begin
            if (clear_end) state_in = WSS_IDLE;
         end
         WSS_IDLE: begin
            if (accept) begin
               case (mode_type'(req_data.mode))
                  MODE_ASSIGN:   state_in = req_rng_ok ? WSS_SEARCH : WSS_RESP;
                  MODE_COMPLETE: state_in = WSS_SEARCH;
                  MODE_RECLAIM:  state_in = WSS_SEARCH;
                  MODE_TAG:      state_in = req_rng_ok ? WSS_PAINT : WSS_RESP;
                  MODE_RELABEL:  state_in = (req_data.old_state == req_data.new_state) ?
                                            WSS_RESP : WSS_PAINT;
                  MODE_QUERY:    state_in = query_bad ? WSS_RESP : WSS_QUERY;
                  default:       state_in = WSS_RESP;
               endcase
            end
         end
         WSS_SEARCH: begin
            if (search_end) begin
               if (mode_ff == MODE_ASSIGN) begin
                  state_in = (search_hit || free_ok_ff) ? WSS_PAINT : WSS_RESP;
               end else begin
                  state_in = (search_hit && slot_rng_ok) ? WSS_PAINT : WSS_RESP;
               end
            end
         end
         WSS_PAINT: begin
            if (paint_end) state_in = WSS_RESP;
         end
         WSS_QUERY: state_in = WSS_QWAIT;
         WSS_QWAIT: state_in = WSS_RESP;
         WSS_RESP: begin
            if (!rsp_valid_ff || rsp_ready) state_in = WSS_IDLE;
         end
         default: state_in = WSS_IDLE;
      endcase
      if (csr_wr_en) state_in = WSS_CLEAR;
   end

   always_comb begin
      mode_in      = mode_ff;
      key_in       = key_ff;
      b_in         = b_ff;
      e_in         = e_ff;
      ost_in       = ost_ff;
      idx_in       = idx_ff;
      job_in       = job_ff;
      cnt_in       = cnt_ff;
      valid_in     = valid_ff;
      sp_in        = sp_ff;
      rd_live_in   = 1'b0;
      rd_slot_in   = rd_slot_ff;
      free_ok_in   = free_ok_ff;
      free_slot_in = free_slot_ff;
      ptr_in       = ptr_ff;
      lim_in       = lim_ff;
      p_live_in    = 1'b0;
      p_addr_in    = p_addr_ff;
      pnew_in      = pnew_ff;
      pfilt_in     = pfilt_ff;
      status_in    = status_ff;
      start_in     = start_ff;
      qst_in       = qst_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      e_wr_en      = 1'b0;
      e_wr_addr    = p_addr_ff;
      e_wr_data    = pnew_ff;
      e_rd_addr    = ptr_ff[AW-1:0];
      s_wr_en      = 1'b0;
      s_wr_addr    = rd_slot_ff;
      s_wr_data    = '{key: key_ff, first: b_ff, last: e_ff};

      case (state_ff)
         WSS_CLEAR: begin
            e_wr_en   = 1'b1;
            e_wr_addr = ptr_ff[AW-1:0];
            e_wr_data = ENTRY_TODO;
            ptr_in    = ptr_ff + CW'(1);
         end
         WSS_IDLE: begin
            if (accept) begin
               mode_in    = req_data.mode;
               key_in     = req_key;
               b_in       = req_data.seg_begin;
               e_in       = req_data.seg_end;
               ost_in     = req_data.old_state;
               idx_in     = req_data.entry_index;
               status_in  = STATUS_OK;
               start_in   = '0;
               qst_in     = ENTRY_TODO;
               sp_in      = '0;
               free_ok_in = 1'b0;
               ptr_in     = CW'(req_data.seg_begin);
               lim_in     = CW'(req_data.seg_end);
               pnew_in    = req_data.new_state;
               pfilt_in   = 1'b0;
               case (mode_type'(req_data.mode))
                  MODE_ASSIGN, MODE_TAG: begin
                     if (!req_rng_ok) status_in = STATUS_RANGE;
                  end
                  MODE_RELABEL: begin
                     ptr_in   = '0;
                     lim_in   = CW'(job_ff);
                     pfilt_in = 1'b1;
                  end
                  MODE_QUERY: begin
                     if (query_bad) status_in = STATUS_RANGE;
                  end
                  default: ;
               endcase
            end
         end
         WSS_SEARCH: begin
            e_rd_addr = ptr_ff[AW-1:0];
            if (sp_ff < (SW+1)'(CLIENT_SLOTS)) begin
               if (!valid_ff[sp_ff[SW-1:0]] && !free_ok_ff) begin
                  free_ok_in   = 1'b1;
                  free_slot_in = sp_ff[SW-1:0];
               end
               rd_live_in = 1'b1;
               rd_slot_in = sp_ff[SW-1:0];
               sp_in      = sp_ff + (SW+1)'(1);
            end
            if (search_end) begin
               rd_live_in = 1'b0;
               if (mode_ff == MODE_ASSIGN) begin
                  if (search_hit || free_ok_ff) begin
                     s_wr_en   = 1'b1;
                     s_wr_addr = search_hit ? rd_slot_ff : free_slot_ff;
                     valid_in[s_wr_addr] = 1'b1;
                     ptr_in    = CW'(b_ff);
                     lim_in    = CW'(e_ff);
                     pnew_in   = ENTRY_INPROG;
                  end else begin
                     status_in = STATUS_FULL;
                  end
               end else if (search_hit) begin
                  valid_in[rd_slot_ff] = 1'b0;
                  start_in = s_rd.first;
                  ptr_in   = CW'(s_rd.first);
                  lim_in   = CW'(s_rd.last);
                  pnew_in  = (mode_ff == MODE_COMPLETE) ? ENTRY_DONE : ENTRY_TODO;
                  if (!slot_rng_ok) status_in = STATUS_RANGE;
               end else begin
                  status_in = STATUS_NOCLIENT;
               end
            end
         end
         WSS_PAINT: begin
            if (ptr_ff < lim_ff) begin
               p_live_in = 1'b1;
               p_addr_in = ptr_ff[AW-1:0];
               ptr_in    = ptr_ff + CW'(1);
            end
            if (p_write) begin
               e_wr_en = 1'b1;
               if (e_rd_data != pnew_ff) begin
                  cnt_in[e_rd_data] = cnt_ff[e_rd_data] - FIELD_W'(1);
                  cnt_in[pnew_ff]   = cnt_ff[pnew_ff] + FIELD_W'(1);
               end
            end
         end
         WSS_QUERY: begin
            e_rd_addr = AW'(idx_ff);
         end
         WSS_QWAIT: begin
            qst_in = e_rd_data;
         end
         WSS_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: status_ff, seg_start: start_ff, entry_state: qst_ff,
                          todo_count: cnt_ff[ENTRY_TODO],
                          inprogress_count: cnt_ff[ENTRY_INPROG],
                          done_count: cnt_ff[ENTRY_DONE],
                          fail_count: cnt_ff[ENTRY_FAIL]};
            end
         end
         default: ;
      endcase

      if (csr_wr_en) begin
         job_in    = clamp_size(csr_wr_data);
         cnt_in[ENTRY_TODO]   = clamp_size(csr_wr_data);
         cnt_in[ENTRY_INPROG] = '0;
         cnt_in[ENTRY_DONE]   = '0;
         cnt_in[ENTRY_FAIL]   = '0;
         valid_in  = '0;
         ptr_in    = '0;
         p_live_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= WSS_CLEAR;
         job_ff       <= clamp_size(13'd4096);
         cnt_ff[ENTRY_TODO]   <= clamp_size(13'd4096);
         cnt_ff[ENTRY_INPROG] <= '0;
         cnt_ff[ENTRY_DONE]   <= '0;
         cnt_ff[ENTRY_FAIL]   <= '0;
         valid_ff     <= '0;
         ptr_ff       <= '0;
         sp_ff        <= '0;
         rd_live_ff   <= 1'b0;
         free_ok_ff   <= 1'b0;
         p_live_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         ptr_ff       <= ptr_in;
         sp_ff        <= sp_in;
         rd_live_ff   <= rd_live_in;
         free_ok_ff   <= free_ok_in;
         p_live_ff    <= p_live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      key_ff       <= key_in;
      b_ff         <= b_in;
      e_ff         <= e_in;
      ost_ff       <= ost_in;
      idx_ff       <= idx_in;
      rd_slot_ff   <= rd_slot_in;
      free_slot_ff <= free_slot_in;
      lim_ff       <= lim_in;
      p_addr_ff    <= p_addr_in;
      pnew_ff      <= pnew_in;
      pfilt_ff     <= pfilt_in;
      status_ff    <= status_in;
      start_ff     <= start_in;
      qst_ff       <= qst_in;
      rsp_ff       <= rsp_in;
   end

   wss_ram #(.WIDTH(2), .DEPTH(NUM_ENTRIES)) u_entry_ram (
      .clock   (clock),
      .wr_en   (e_wr_en),
      .wr_addr (e_wr_addr),
      .wr_data (e_wr_data),
      .rd_addr (e_rd_addr),
      .rd_data (e_rd_data)
   );

   wss_ram #(.WIDTH(SLOT_W), .DEPTH(CLIENT_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (s_wr_addr),
      .wr_data (s_wr_data),
      .rd_addr (sp_ff[SW-1:0]),
      .rd_data (s_rd_raw)
   );

   assign req_ready = state_ff == WSS_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_sum: assert property (@(posedge clock) disable iff (reset)
      (15'(cnt_ff[ENTRY_TODO]) + 15'(cnt_ff[ENTRY_INPROG]) + 15'(cnt_ff[ENTRY_DONE]) +
       15'(cnt_ff[ENTRY_FAIL])) == 15'(job_ff))
      else $error("state counts do not add up to job size");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && !csr_wr_en) |=> (state_ff != WSS_IDLE))
      else $error("accepted request left the sequencer idle");
   a_paint_live: assert property (@(posedge clock) disable iff (reset)
      p_live_ff |-> (state_ff == WSS_PAINT))
      else $error("entry write pending outside paint sweep");
   a_noclient_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_NOCLIENT)) |-> (rsp_data.seg_start == '0))
      else $error("missing client reported a segment start");
`endif

endmodule

// ===== dv/work_segment_scoreboard_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Work segment scoreboard core testbench
// Drives assign, complete, reclaim, tag, relabel and query requests with
// random idle gaps on both channels, predicts every response with a local
// model of the entry store, counts and client table, and compares each
// whole response in order.
// ----------------------------------------------------------------------------
module work_segment_scoreboard_core_tb;

   import wss_pkg::*;

   localparam int NUM_ENTRIES  = 4096;
   localparam int CLIENT_SLOTS = 64;
   localparam longint CYCLE_LIMIT = 4000000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_wr_en;
   logic [12:0] csr_wr_data;

   logic [1:0]  board_state [NUM_ENTRIES];
   int          board_count [4];
   int          board_size;
   bit          client_used [CLIENT_SLOTS];
   logic [47:0] client_key [CLIENT_SLOTS];
   int          client_first [CLIENT_SLOTS];
   int          client_last [CLIENT_SLOTS];

   rsp_type     pending_rsp [$];
   int          mismatch_count;
   longint      cycle_count;
   bit          hold_rsp;
   logic [31:0] known_ip [8];
   logic [15:0] known_port [8];

   work_segment_scoreboard_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic void board_clear(int size);
      for (int i = 0; i < NUM_ENTRIES; i++) board_state[i] = ENTRY_TODO;
      board_count[ENTRY_TODO] = size;
      board_count[ENTRY_INPROG] = 0;
      board_count[ENTRY_DONE] = 0;
      board_count[ENTRY_FAIL] = 0;
      for (int s = 0; s < CLIENT_SLOTS; s++) client_used[s] = 1'b0;
   endfunction

   function automatic void board_paint(int b, int e, logic [1:0] st);
      for (int i = b; i < e && i < NUM_ENTRIES; i++) begin
         board_count[board_state[i]]--;
         board_state[i] = st;
         board_count[st]++;
      end
   endfunction

   function automatic int client_find(logic [47:0] key);
      for (int s = 0; s < CLIENT_SLOTS; s++)
         if (client_used[s] && client_key[s] == key) return s;
      return -1;
   endfunction

   function automatic int client_free();
      for (int s = 0; s < CLIENT_SLOTS; s++)
         if (!client_used[s]) return s;
      return -1;
   endfunction

   function automatic rsp_type board_apply(req_type rq);
      rsp_type     r;
      logic [47:0] key;
      int          b;
      int          e;
      int          s;
      key = {rq.client_ip, rq.client_port};
      b = int'(rq.seg_begin);
      e = int'(rq.seg_end);
      r = '0;
      r.status = STATUS_OK;
      case (rq.mode)
         MODE_ASSIGN: begin
            if (b > board_size || e > board_size) r.status = STATUS_RANGE;
            else begin
               s = client_find(key);
               if (s < 0) s = client_free();
               if (s < 0) r.status = STATUS_FULL;
               else begin
                  client_used[s] = 1'b1;
                  client_key[s] = key;
                  client_first[s] = b;
                  client_last[s] = e;
                  board_paint(b, e, ENTRY_INPROG);
               end
            end
         end
         MODE_COMPLETE, MODE_RECLAIM: begin
            s = client_find(key);
            if (s < 0) r.status = STATUS_NOCLIENT;
            else begin
               client_used[s] = 1'b0;
               r.seg_start = 13'(client_first[s]);
               if (client_first[s] <= board_size && client_last[s] <= board_size)
                  board_paint(client_first[s], client_last[s],
                              rq.mode == MODE_COMPLETE ? ENTRY_DONE : ENTRY_TODO);
               else r.status = STATUS_RANGE;
            end
         end
         MODE_TAG: begin
            if (b > board_size || e > board_size) r.status = STATUS_RANGE;
            else board_paint(b, e, rq.new_state);
         end
         MODE_RELABEL: begin
            if (rq.old_state != rq.new_state)
               for (int i = 0; i < board_size && i < NUM_ENTRIES; i++)
                  if (board_state[i] == rq.old_state) begin
                     board_state[i] = rq.new_state;
                     board_count[rq.old_state]--;
                     board_count[rq.new_state]++;
                  end
         end
         MODE_QUERY: begin
            if (int'(rq.entry_index) >= board_size) r.status = STATUS_RANGE;
            else r.entry_state = board_state[rq.entry_index];
         end
         default: ;
      endcase
      r.todo_count = 13'(board_count[ENTRY_TODO]);
      r.inprogress_count = 13'(board_count[ENTRY_INPROG]);
      r.done_count = 13'(board_count[ENTRY_DONE]);
      r.fail_count = 13'(board_count[ENTRY_FAIL]);
      return r;
   endfunction

   task automatic send_request(req_type rq, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (!req_ready);
      pending_rsp.insert(pending_rsp.size(), board_apply(rq));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (NUM_ENTRIES + 200) @(posedge clock);
   endtask

   task automatic write_job_size(logic [12:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board_size = (int'(value) > NUM_ENTRIES) ? NUM_ENTRIES : int'(value);
      board_clear(board_size);
   endtask

   function automatic req_type random_request();
      req_type rq;
      int      k;
      int      len;
      rq = '0;
      rq.mode = 3'($urandom_range(0, 7));
      rq.client_ip = $urandom();
      rq.client_port = 16'($urandom());
      if ($urandom_range(0, 3) != 0) begin
         k = $urandom_range(0, 7);
         rq.client_ip = known_ip[k];
         rq.client_port = known_port[k];
      end
      rq.seg_begin = 13'($urandom_range(0, board_size));
      len = $urandom_range(0, 9) == 0 ? $urandom_range(0, 400) : $urandom_range(0, 40);
      rq.seg_end = 13'(int'(rq.seg_begin) + len);
      if ($urandom_range(0, 15) == 0) begin
         rq.seg_begin = 13'($urandom());
         rq.seg_end = 13'($urandom());
      end
      rq.new_state = 2'($urandom());
      rq.old_state = 2'($urandom());
      rq.entry_index = 12'($urandom());
      if ($urandom_range(0, 2) != 0 && board_size > 0)
         rq.entry_index = 12'($urandom_range(int'(rq.seg_begin), int'(rq.seg_begin) + 40)
                              % board_size);
      if (rq.mode > 5 && $urandom_range(0, 3) != 0) rq.mode = MODE_QUERY;
      if (rq.mode == MODE_RELABEL && $urandom_range(0, 2) != 0) rq.mode = MODE_TAG;
      return rq;
   endfunction

   function automatic req_type make_request(logic [2:0] mode, logic [31:0] ip,
                                            logic [15:0] port, int b, int e,
                                            logic [1:0] ns, logic [1:0] os, int idx);
      req_type rq;
      rq.mode = mode;
      rq.client_ip = ip;
      rq.client_port = port;
      rq.seg_begin = 13'(b);
      rq.seg_end = 13'(e);
      rq.new_state = ns;
      rq.old_state = os;
      rq.entry_index = 12'(idx);
      return rq;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected response %p", rsp_data);
            end else begin
               if (rsp_data !== pending_rsp[0]) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Mismatch: expected %p, actual %p",
                              pending_rsp[0], rsp_data);
               end
               void'(pending_rsp.pop_front());
            end
         end
      end
   end

   initial begin : rsp_stall
      int gap;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (3000) @(posedge clock);
            hold_rsp = 1'b0;
         end
         gap = $urandom_range(0, 17);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic test_directed();
      send_request(make_request(MODE_QUERY, 0, 0, 0, 0, ENTRY_TODO, ENTRY_TODO, 0));
      send_request(make_request(MODE_QUERY, 0, 0, 0, 0, ENTRY_TODO, ENTRY_TODO, 4095));
      send_request(make_request(MODE_ASSIGN, 32'hFFFF_FFFF, 16'hFFFF, 0, 40,
                                ENTRY_TODO, ENTRY_TODO, 0));
      send_request(make_request(MODE_ASSIGN, 32'h0, 16'h0, 4000, 4096,
                                ENTRY_TODO, ENTRY_TODO, 0));
      send_request(make_request(MODE_ASSIGN, 32'h1, 16'h1, 4096, 4097,
                                ENTRY_TODO, ENTRY_TODO, 0));
      send_request(make_request(MODE_ASSIGN, 32'h1, 16'h1, 8191, 0,
                                ENTRY_TODO, ENTRY_TODO, 0));
      send_request(make_request(MODE_ASSIGN, 32'hFFFF_FFFF, 16'hFFFF, 20, 60,
                                ENTRY_TODO, ENTRY_TODO, 0));
      send_request(make_request(MODE_ASSIGN, 32'h2, 16'h2, 50, 10,
                                ENTRY_TODO, ENTRY_TODO, 0));
      send_request(make_request(MODE_QUERY, 0, 0, 0, 0, ENTRY_TODO, ENTRY_TODO, 25));
      send_request(make_request(MODE_COMPLETE, 32'hFFFF_FFFF, 16'hFFFF, 0, 0,
                                ENTRY_TODO, ENTRY_TODO, 0));
      send_request(make_request(MODE_COMPLETE, 32'hFFFF_FFFF, 16'hFFFF, 0, 0,
                                ENTRY_TODO, ENTRY_TODO, 0));
      send_request(make_request(MODE_RECLAIM, 32'h0, 16'h0, 0, 0,
                                ENTRY_TODO, ENTRY_TODO, 0));
      send_request(make_request(MODE_RECLAIM, 32'h3, 16'h3, 0, 0,
                                ENTRY_TODO, ENTRY_TODO, 0));
      send_request(make_request(MODE_TAG, 0, 0, 100, 8191, ENTRY_FAIL, ENTRY_TODO, 0));
      send_request(make_request(MODE_TAG, 0, 0, 100, 140, ENTRY_FAIL, ENTRY_TODO, 0));
      send_request(make_request(MODE_RELABEL, 0, 0, 0, 0, ENTRY_FAIL, ENTRY_FAIL, 0));
      send_request(make_request(MODE_RELABEL, 0, 0, 0, 0, ENTRY_TODO, ENTRY_DONE, 0));
      send_request(make_request(MODE_RELABEL, 0, 0, 0, 0, ENTRY_INPROG, ENTRY_TODO, 0));
      send_request(make_request(3'd6, 0, 0, 0, 0, ENTRY_TODO, ENTRY_TODO, 0));
      send_request(make_request(3'd7, 0, 0, 0, 0, ENTRY_TODO, ENTRY_TODO, 0));
      send_request(make_request(MODE_QUERY, 0, 0, 0, 0, ENTRY_TODO, ENTRY_TODO, 120));
   endtask

   task automatic test_table_full();
      write_job_size(13'd200);
      for (int c = 0; c <= CLIENT_SLOTS; c++)
         send_request(make_request(MODE_ASSIGN, 32'h0A00_0000 + c, 16'd80, c, c + 2,
                                   ENTRY_TODO, ENTRY_TODO, 0));
      send_request(make_request(MODE_COMPLETE, 32'h0A00_0005, 16'd80, 0, 0,
                                ENTRY_TODO, ENTRY_TODO, 0));
      send_request(make_request(MODE_ASSIGN, 32'h0B00_0000, 16'd81, 150, 200,
                                ENTRY_TODO, ENTRY_TODO, 0));
      send_request(make_request(MODE_QUERY, 0, 0, 0, 0, ENTRY_TODO, ENTRY_TODO, 199));
      send_request(make_request(MODE_QUERY, 0, 0, 0, 0, ENTRY_TODO, ENTRY_TODO, 200));
   endtask

   task automatic test_backpressure();
      hold_rsp = 1'b1;
      for (int n = 0; n < 20; n++) send_request(random_request(), 1);
      drain();
   endtask

   task automatic test_random(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 7) == 0)
            for (int k = 0; k < 8; k++) begin
               known_ip[k] = $urandom();
               known_port[k] = 16'($urandom());
            end
         send_request(random_request());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      hold_rsp = 1'b0;
      mismatch_count = 0;
      cycle_count = 0;
      board_size = NUM_ENTRIES;
      board_clear(board_size);
      for (int k = 0; k < 8; k++) begin
         known_ip[k] = $urandom();
         known_port[k] = 16'($urandom());
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_table_full();
      write_job_size(13'd0);
      test_random(30);
      write_job_size(13'd8191);
      test_random(150);
      test_backpressure();
      write_job_size(13'd64);
      test_random(200);
      write_job_size(13'd4096);
      test_random(200);
      drain();
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
